// File: hdl/msbr_pkg.sv
// Package for the MSB-first bitstream reader: item kinds, status codes,
// field widths, packing layout and the structs between the top level and the fetch unit.
// No dependencies.
package msbr_pkg;

    // Field widths of the stream items.
    localparam int KIND_W   = 2;
    localparam int DATA_W   = 8;
    localparam int WANT_W   = 6;
    localparam int SEEK_W   = 13;
    localparam int BITP_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // Widest read; a larger request is saturated to it.
    localparam int MAX_READ_BITS = 32;
    // Bytes a widest read can touch, counter width and accumulator width.
    localparam int NB_MAX = (MAX_READ_BITS + 14) / 8;
    localparam int NB_W   = $clog2(NB_MAX + 1);
    localparam int ACC_W  = 8 * NB_MAX;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 56;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEEK   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SEEK  = 2'd3;

    // Request from the sequencer to the fetch unit.
    typedef struct packed {
        logic              start;
        logic [NB_W-1:0]   nbytes;
        logic [BITP_W-1:0] tail;
        logic [WANT_W-1:0] want;
    } fetch_req_t;

    // Answer of the fetch unit.
    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] value;
    } fetch_rsp_t;

endpackage

// File: hdl/msbr_fetch.sv
// Fetch unit of the MSB-first bitstream reader: the byte store memory, the byte-by-byte
// read sequence and the final alignment of the extracted bits.
// Depends on msbr_pkg.
module msbr_fetch
    import msbr_pkg::*;
#(
    parameter int STORE_BYTES = 4096
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [$clog2(STORE_BYTES)-1:0] wr_addr,
    input  logic [DATA_W-1:0]              wr_data,
    input  fetch_req_t                     req,
    input  logic [$clog2(STORE_BYTES)-1:0] req_addr,
    output fetch_rsp_t                     rsp
);

    localparam int ADDR_W = $clog2(STORE_BYTES);

    logic [DATA_W-1:0] mem [STORE_BYTES];
    logic [DATA_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] addr_reg;
    logic              active_reg;
    logic [NB_W-1:0]   cnt_reg;
    logic [BITP_W-1:0] tail_reg;
    logic [WANT_W-1:0] want_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  word;
    logic [ACC_W-1:0]  shifted;

    // The first byte comes from the request, the rest from consecutive addresses.
    assign rd_addr = req.start ? req_addr : addr_reg + ADDR_W'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        addr_reg    <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (req.start)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= req.nbytes;
        end
        else if (active_reg)
        begin
            cnt_reg <= cnt_reg - NB_W'(1);
            if (cnt_reg == NB_W'(1))
            begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            tail_reg <= req.tail;
            want_reg <= req.want;
        end
        if (active_reg)
        begin
            acc_reg <= {acc_reg[ACC_W-DATA_W-1:0], rd_data_reg};
        end
    end

    // Bytes gathered so far plus the one arriving now; the unused low bits of the
    // last byte are dropped and only the requested bits are kept.
    assign word    = {acc_reg[ACC_W-DATA_W-1:0], rd_data_reg};
    assign shifted = word >> tail_reg;

    assign rsp.done  = active_reg && (cnt_reg == NB_W'(1));
    assign rsp.value = shifted[VALUE_W-1:0] & ~({VALUE_W{1'b1}} << want_reg);

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !active_reg)
        else $error("fetch started while a fetch is running");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (cnt_reg != '0) && (cnt_reg <= NB_W'(NB_MAX)))
        else $error("fetch byte count out of range");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !active_reg)
        else $error("fetch still running after its last byte");

endmodule

// File: hdl/msb_first_bitstream_reader_top.sv
// Top level of the MSB-first bitstream reader: stream ports, item sequencer,
// fill count and cursor registers, result register. Depends on msbr_pkg and msbr_fetch.
//
//  Channel   | Dir | Signals                           | Contents
//  ----------+-----+-----------------------------------+--------------------------------------
//  input     | in  | s_tvalid s_tready s_tdata s_tuser | one command item (append/read/seek/clear)
//  result    | out | m_tvalid m_tready m_tdata         | one result item per command item
//
// An append, a seek, a clear, a zero-bit read and a read that is short of data
// need no fetch from the store. A read that succeeds fetches the n stored bytes
// that the requested bits touch (up to five for a 32-bit read); the store has one
// registered read port and delivers one byte a cycle.
// A result that cannot enter the output register because an earlier result is
// still waiting is parked, and the reader takes no item until it has moved on.
// Reset clears the fill count and the cursor; the store contents are not cleared,
// since only bytes below the fill count are ever read.
module msb_first_bitstream_reader_top
    import msbr_pkg::*;
#(
    parameter int STORE_BYTES = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: data_byte[7:0], bits_wanted[13:8], seek_byte[26:14], seek_bit[29:27],
    // zero padding[31:30].
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: kind[1:0].
    input  logic [KIND_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: value[31:0], status[33:32], byte_pos[46:34], bit_pos[49:47],
    // aligned[50], more_avail[51], zero padding[55:52].
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int ADDR_W = $clog2(STORE_BYTES);
    // The cursor and the fill count must be able to hold STORE_BYTES itself.
    localparam int POS_W  = ADDR_W + 1;
    localparam int CUR_W  = POS_W + BITP_W;
    localparam int CMP_W  = (POS_W > SEEK_W) ? CUR_W : SEEK_W + BITP_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;

    // Input fields.
    logic [KIND_W-1:0] in_kind;
    logic [DATA_W-1:0] in_data_byte;
    logic [WANT_W-1:0] in_bits_wanted;
    logic [SEEK_W-1:0] in_seek_byte;
    logic [BITP_W-1:0] in_seek_bit;

    assign in_kind        = s_tuser;
    assign in_data_byte   = s_tdata[7:0];
    assign in_bits_wanted = s_tdata[13:8];
    assign in_seek_byte   = s_tdata[26:14];
    assign in_seek_bit    = s_tdata[29:27];

    // Store state.
    logic [POS_W-1:0]  fill_reg, fill_next;
    logic [POS_W-1:0]  byte_pos_reg, byte_pos_next;
    logic [BITP_W-1:0] bit_pos_reg, bit_pos_next;

    // A result waiting for the output register.
    logic [VALUE_W-1:0]  pend_value_reg, pend_value_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;

    // Output register.
    logic                m_tvalid_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SEEK_W-1:0]   out_byte_reg;
    logic [BITP_W-1:0]   out_bit_reg;
    logic                out_aligned_reg;
    logic                out_more_reg;

    logic                s_accept;
    logic                out_free;
    logic                out_load;
    logic [VALUE_W-1:0]  load_value;
    logic [STATUS_W-1:0] load_status;
    logic                emit;
    logic [VALUE_W-1:0]  res_value;
    logic [STATUS_W-1:0] res_status;
    logic                more_next;

    // Read bookkeeping.
    logic [WANT_W-1:0] want;
    logic [CUR_W-1:0]  cur_bits;
    logic [CUR_W-1:0]  end_bits;
    logic [CUR_W-1:0]  avail_bits;
    logic [CUR_W-1:0]  new_cur;
    logic              read_short;
    logic [6:0]        span;
    logic [CMP_W-1:0]  seek_bits;
    logic [CMP_W-1:0]  fill_bits;

    logic              wr_en;
    logic              fetch_start;
    fetch_req_t        req;
    fetch_rsp_t        rsp;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign want       = (in_bits_wanted > WANT_W'(MAX_READ_BITS)) ? WANT_W'(MAX_READ_BITS)
                                                                  : in_bits_wanted;
    assign cur_bits   = {byte_pos_reg, bit_pos_reg};
    assign end_bits   = {fill_reg, {BITP_W{1'b0}}};
    assign avail_bits = (end_bits > cur_bits) ? end_bits - cur_bits : '0;
    assign read_short = CUR_W'(want) > avail_bits;
    assign new_cur    = cur_bits + CUR_W'(want);
    assign span       = 7'(bit_pos_reg) + 7'(want);
    assign seek_bits  = CMP_W'({in_seek_byte, in_seek_bit});
    assign fill_bits  = CMP_W'(end_bits);

    // Fetch request: bytes touched, and the unused bits after the last wanted bit.
    assign req.start  = fetch_start;
    assign req.nbytes = NB_W'((span + 7'd7) >> 3);
    assign req.tail   = BITP_W'(-span);
    assign req.want   = want;

    msbr_fetch #(
        .STORE_BYTES (STORE_BYTES)
    ) u_fetch (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (fill_reg[ADDR_W-1:0]),
        .wr_data  (in_data_byte),
        .req      (req),
        .req_addr (byte_pos_reg[ADDR_W-1:0]),
        .rsp      (rsp)
    );

    // Sequencer. The cursor moves when the item is taken; the fetch unit works
    // from the positions captured in its request.
    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        byte_pos_next    = byte_pos_reg;
        bit_pos_next     = bit_pos_reg;
        pend_value_next  = pend_value_reg;
        pend_status_next = pend_status_reg;
        emit             = 1'b0;
        res_value        = '0;
        res_status       = ST_OK;
        wr_en            = 1'b0;
        fetch_start      = 1'b0;
        out_load         = 1'b0;
        load_value       = pend_value_reg;
        load_status      = pend_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    case (in_kind)
                        KIND_APPEND:
                        begin
                            emit = 1'b1;
                            if (fill_reg == POS_W'(STORE_BYTES))
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + POS_W'(1);
                            end
                        end
                        KIND_READ:
                        begin
                            if (read_short)
                            begin
                                emit       = 1'b1;
                                res_status = ST_SHORT;
                            end
                            else if (want == '0)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                fetch_start   = 1'b1;
                                byte_pos_next = new_cur[CUR_W-1:BITP_W];
                                bit_pos_next  = new_cur[BITP_W-1:0];
                                state_next    = S_READ;
                            end
                        end
                        KIND_SEEK:
                        begin
                            emit = 1'b1;
                            if (seek_bits > fill_bits)
                            begin
                                res_status = ST_SEEK;
                            end
                            else
                            begin
                                byte_pos_next = POS_W'(in_seek_byte);
                                bit_pos_next  = in_seek_bit;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            emit          = 1'b1;
                            fill_next     = '0;
                            byte_pos_next = '0;
                            bit_pos_next  = '0;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (rsp.done)
                begin
                    emit      = 1'b1;
                    res_value = rsp.value;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished result goes straight to the output register when it is free.
        if (emit)
        begin
            if (out_free)
            begin
                out_load    = 1'b1;
                load_value  = res_value;
                load_status = res_status;
                state_next  = S_IDLE;
            end
            else
            begin
                pend_value_next  = res_value;
                pend_status_next = res_status;
                state_next       = S_DONE;
            end
        end
    end

    assign more_next = ({1'b0, byte_pos_next} + (POS_W + 1)'(1)) < {1'b0, fill_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            byte_pos_reg <= '0;
            bit_pos_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            byte_pos_reg <= byte_pos_next;
            bit_pos_reg  <= bit_pos_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_value_reg  <= pend_value_next;
        pend_status_reg <= pend_status_next;
        if (out_load)
        begin
            out_value_reg   <= load_value;
            out_status_reg  <= load_status;
            out_byte_reg    <= SEEK_W'(byte_pos_next);
            out_bit_reg     <= bit_pos_next;
            out_aligned_reg <= (bit_pos_next == '0);
            out_more_reg    <= more_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_more_reg, out_aligned_reg, out_bit_reg, out_byte_reg,
                       out_status_reg, out_value_reg};

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= POS_W'(STORE_BYTES))
        else $error("fill count beyond store size");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_bits <= end_bits)
        else $error("cursor beyond the filled part of the store");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg != S_IDLE) || m_tvalid_reg)
        else $error("accepted item produced neither work nor a result");

endmodule
